FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/esa_pkg.sv
// shared opcode and funct codes and the alu result type
package esa_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 6;
  localparam int unsigned ImmW    = 16;
  localparam int unsigned ShamtW  = 5;

  // opcodes
  localparam logic [OpW-1:0] OP_RTYPE = 6'd0;
  localparam logic [OpW-1:0] OP_JAL   = 6'd3;
  localparam logic [OpW-1:0] OP_ADDI  = 6'd8;
  localparam logic [OpW-1:0] OP_ADDIU = 6'd9;
  localparam logic [OpW-1:0] OP_SLTI  = 6'd10;
  localparam logic [OpW-1:0] OP_ANDI  = 6'd12;
  localparam logic [OpW-1:0] OP_ORI   = 6'd13;
  localparam logic [OpW-1:0] OP_NORI  = 6'd14;
  localparam logic [OpW-1:0] OP_LUI   = 6'd15;
  localparam logic [OpW-1:0] OP_LB    = 6'd32;
  localparam logic [OpW-1:0] OP_LH    = 6'd33;
  localparam logic [OpW-1:0] OP_LW    = 6'd35;
  localparam logic [OpW-1:0] OP_LBU   = 6'd36;
  localparam logic [OpW-1:0] OP_LHU   = 6'd37;
  localparam logic [OpW-1:0] OP_SB    = 6'd40;
  localparam logic [OpW-1:0] OP_SH    = 6'd41;
  localparam logic [OpW-1:0] OP_SW    = 6'd43;

  // r-type funct codes
  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_NAND = 6'd40;
  localparam logic [5:0] FN_SLT  = 6'd42;

  localparam logic [DataW-1:0] LinkOffset = 32'd4;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             overflow;
    logic             has_result;
  } alu_out_t;

endpackage

FILE: rtl/core/esa_alu.sv
// combinational alu: one shared adder, logic unit, compare and shifter
module esa_alu (
  input  logic [esa_pkg::OpW-1:0]   opcode,
  input  logic [esa_pkg::ImmW-1:0]  instr_low,
  input  logic [esa_pkg::DataW-1:0] rs_value,
  input  logic [esa_pkg::DataW-1:0] rt_value,
  input  logic [esa_pkg::DataW-1:0] pc,
  output esa_pkg::alu_out_t         alu_out
);
  import esa_pkg::*;

  logic [5:0]        funct;
  logic [ShamtW-1:0] shamt;
  logic [DataW-1:0]  zimm;
  logic [DataW-1:0]  simm;
  logic              rtype;
  logic              is_sub;
  logic [DataW-1:0]  add_a;
  logic [DataW-1:0]  add_b;
  logic [DataW-1:0]  add_bx;
  logic [DataW-1:0]  sum;
  logic              sum_ovf;
  logic [DataW-1:0]  cmp_b;
  logic              less;

  assign funct  = instr_low[5:0];
  assign shamt  = instr_low[10:6];
  assign zimm   = {{(DataW-ImmW){1'b0}}, instr_low};
  assign simm   = {{(DataW-ImmW){instr_low[ImmW-1]}}, instr_low};
  assign rtype  = (opcode == OP_RTYPE);
  assign is_sub = rtype && (funct == FN_SUB);

  // one adder serves add, sub, immediate adds, addresses and the link
  assign add_a  = (opcode == OP_JAL) ? pc : rs_value;
  assign add_b  = rtype ? rt_value : ((opcode == OP_JAL) ? LinkOffset : simm);
  assign add_bx = add_b ^ {DataW{is_sub}};
  assign sum    = add_a + add_bx + {{(DataW-1){1'b0}}, is_sub};
  // sign rule on the effective addend covers both add and subtract
  assign sum_ovf = (add_a[DataW-1] ^ sum[DataW-1]) & (add_bx[DataW-1] ^ sum[DataW-1]);

  assign cmp_b = rtype ? rt_value : simm;
  assign less  = ($signed(rs_value) < $signed(cmp_b));

  always_comb begin
    alu_out = '0;
    alu_out.has_result = 1'b1;
    unique case (opcode)
      OP_RTYPE: begin
        unique case (funct)
          FN_ADD: begin
            alu_out.result   = sum;
            alu_out.overflow = sum_ovf;
          end
          FN_ADDU: alu_out.result = sum;
          FN_SUB: begin
            alu_out.result   = sum;
            alu_out.overflow = sum_ovf;
          end
          FN_AND:  alu_out.result = rs_value & rt_value;
          FN_OR:   alu_out.result = rs_value | rt_value;
          FN_XOR:  alu_out.result = rs_value ^ rt_value;
          FN_NOR:  alu_out.result = ~(rs_value | rt_value);
          FN_NAND: alu_out.result = ~(rs_value & rt_value);
          FN_SLT:  alu_out.result = {{(DataW-1){1'b0}}, less};
          FN_SLL:  alu_out.result = rt_value << shamt;
          FN_SRL:  alu_out.result = rt_value >> shamt;
          FN_SRA:  alu_out.result = DataW'($signed(rt_value) >>> shamt);
          default: alu_out.has_result = 1'b0;
        endcase
      end
      OP_ADDI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
        alu_out.result   = sum;
        alu_out.overflow = sum_ovf;
      end
      OP_ADDIU: alu_out.result = sum;
      OP_SLTI:  alu_out.result = {{(DataW-1){1'b0}}, less};
      OP_ANDI:  alu_out.result = rs_value & zimm;
      OP_ORI:   alu_out.result = rs_value | zimm;
      OP_NORI:  alu_out.result = ~(rs_value | zimm);
      OP_LUI:   alu_out.result = {instr_low, {(DataW-ImmW){1'b0}}};
      OP_JAL:   alu_out.result = sum;
      default:  alu_out.has_result = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/execute_stage_alu.sv
// execute-stage alu: input register, single-pass alu, result register
// an input transfer is captured in the input register, and its result then moves into the
// result register, where out_valid rises, once that register is empty or being drained
// throughput: one item per cycle; while a finished result waits in the result register
// the input register takes one more item and then stalls the input
// reset clears both stage valid bits; operand and result data are not reset
module execute_stage_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [esa_pkg::OpW-1:0]   opcode,
  input  logic [esa_pkg::ImmW-1:0]  instr_low,
  input  logic [esa_pkg::DataW-1:0] rs_value,
  input  logic [esa_pkg::DataW-1:0] rt_value,
  input  logic [esa_pkg::DataW-1:0] pc,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [esa_pkg::DataW-1:0] result,
  output logic                      overflow,
  output logic                      has_result
);
  import esa_pkg::*;
  `include "assert_macros.svh"

  logic             s1_valid;
  logic [OpW-1:0]   s1_opcode;
  logic [ImmW-1:0]  s1_instr_low;
  logic [DataW-1:0] s1_rs_value;
  logic [DataW-1:0] s1_rt_value;
  logic [DataW-1:0] s1_pc;
  alu_out_t         alu_out;
  logic             advance;

  // the result register can take a new value when empty or being drained
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode    <= opcode;
      s1_instr_low <= instr_low;
      s1_rs_value  <= rs_value;
      s1_rt_value  <= rt_value;
      s1_pc        <= pc;
    end
  end

  esa_alu u_alu (
    .opcode    (s1_opcode),
    .instr_low (s1_instr_low),
    .rs_value  (s1_rs_value),
    .rt_value  (s1_rt_value),
    .pc        (s1_pc),
    .alu_out   (alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result     <= alu_out.result;
      overflow   <= alu_out.overflow;
      has_result <= alu_out.has_result;
    end
  end

  `ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && !s1_valid, "valid bits not cleared by reset")
  `ASSERT_CLK(a_no_result_zero, out_valid && !has_result |-> result == '0 && !overflow, "no-result item carries data")
  `ASSERT_CLK(a_ovf_needs_result, out_valid && overflow |-> has_result, "overflow without a result")
  `ASSERT_CLK(a_s1_held, s1_valid && out_valid && out_stall |=> s1_valid, "input stage lost an item")
  `ASSERT_CLK(a_stall_only_full, in_stall |-> s1_valid && out_valid && out_stall, "input stalled without backpressure")

endmodule

FILE: test/execute_stage_alu_tb.sv
// testbench for execute_stage_alu: directed table plus random instructions, checked in order
`timescale 1ns / 100ps

module execute_stage_alu_tb;
  import esa_pkg::*;

  localparam int unsigned NumDirected = 28;
  localparam int unsigned NumItems    = 550;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned HoldAfter   = 150;
  localparam int unsigned DrainAt     = 300;

  // codes the block has no result for
  localparam logic [5:0]     FN_JR     = 6'd8;
  localparam logic [OpW-1:0] OP_J      = 6'd2;
  localparam logic [OpW-1:0] OP_BEQ    = 6'd4;
  localparam logic [OpW-1:0] OP_HALT   = 6'd63;
  localparam logic [OpW-1:0] OP_UNUSED = 6'd34;

  localparam alu_out_t NoResult = '{32'h0, 1'b0, 1'b0};

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ImmW-1:0]  low;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] pc_val;
    logic             typed;
    alu_out_t         want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OpW-1:0]   opcode = '0;
  logic [ImmW-1:0]  instr_low = '0;
  logic [DataW-1:0] rs_value = '0;
  logic [DataW-1:0] rt_value = '0;
  logic [DataW-1:0] pc = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [DataW-1:0] result;
  logic             overflow;
  logic             has_result;

  alu_out_t    pending_results[$];
  alu_out_t    next_expect = NoResult;
  alu_out_t    got_alu;
  alu_out_t    want_alu;
  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned no_result_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  logic [5:0] rtype_functs [12] = '{FN_ADD, FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR,
                                    FN_NOR, FN_NAND, FN_SLT, FN_SLL, FN_SRL, FN_SRA};
  logic [OpW-1:0] itype_ops [16] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI,
                                     OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB,
                                     OP_SH, OP_SW, OP_JAL};

  dir_row_t directed_rows [NumDirected] = '{
    '{OP_RTYPE, {10'd0, FN_ADD}, 32'h7FFFFFFF, 32'h1, 32'h0, 1'b1, '{32'h80000000, 1'b1, 1'b1}},
    '{OP_RTYPE, {10'd0, FN_ADDU}, 32'hFFFFFFFF, 32'h1, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b1}},
    '{OP_RTYPE, {10'd0, FN_SUB}, 32'h80000000, 32'h1, 32'h0, 1'b1, '{32'h7FFFFFFF, 1'b1, 1'b1}},
    '{OP_RTYPE, {10'd0, FN_SUB}, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1,
      '{32'h80000000, 1'b1, 1'b1}},
    '{OP_RTYPE, {10'd0, FN_AND}, 32'hA5A5A5A5, 32'h0F0F0F0F, 32'h0, 1'b0, NoResult},
    '{OP_RTYPE, {10'd0, FN_OR}, 32'hA5A5A5A5, 32'h0F0F0F0F, 32'h0, 1'b0, NoResult},
    '{OP_RTYPE, {10'd0, FN_XOR}, 32'hA5A5A5A5, 32'h0F0F0F0F, 32'h0, 1'b0, NoResult},
    '{OP_RTYPE, {10'd0, FN_NOR}, 32'h0, 32'h0, 32'h0, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b1}},
    '{OP_RTYPE, {10'd0, FN_NAND}, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1,
      '{32'h0, 1'b0, 1'b1}},
    '{OP_RTYPE, {10'd0, FN_SLT}, 32'h80000000, 32'h7FFFFFFF, 32'h0, 1'b1, '{32'h1, 1'b0, 1'b1}},
    '{OP_RTYPE, {5'h00, 5'd31, FN_SLL}, 32'h0, 32'h1, 32'h0, 1'b1, '{32'h80000000, 1'b0, 1'b1}},
    '{OP_RTYPE, {5'h00, 5'd31, FN_SRL}, 32'h0, 32'h80000000, 32'h0, 1'b1, '{32'h1, 1'b0, 1'b1}},
    '{OP_RTYPE, {5'h1F, 5'd31, FN_SRA}, 32'h0, 32'h80000000, 32'h0, 1'b1,
      '{32'hFFFFFFFF, 1'b0, 1'b1}},
    '{OP_RTYPE, {10'd0, FN_JR}, 32'h12345678, 32'h9ABCDEF0, 32'h0, 1'b1, NoResult},
    '{OP_ADDI, 16'h0001, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1, '{32'h80000000, 1'b1, 1'b1}},
    '{OP_ADDIU, 16'h8000, 32'h0, 32'h0, 32'h0, 1'b1, '{32'hFFFF8000, 1'b0, 1'b1}},
    '{OP_SLTI, 16'h0000, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b1, '{32'h1, 1'b0, 1'b1}},
    '{OP_ANDI, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b1, '{32'h0000FFFF, 1'b0, 1'b1}},
    '{OP_ORI, 16'h5678, 32'h12340000, 32'h0, 32'h0, 1'b0, NoResult},
    '{OP_NORI, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b1}},
    '{OP_LUI, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b1, '{32'hFFFF0000, 1'b0, 1'b1}},
    '{OP_JAL, 16'h0000, 32'h0, 32'h0, 32'hFFFFFFFC, 1'b1, '{32'h0, 1'b0, 1'b1}},
    '{OP_LW, 16'h0010, 32'h7FFFFFF0, 32'h0, 32'h0, 1'b1, '{32'h80000000, 1'b1, 1'b1}},
    '{OP_SW, 16'hFFFF, 32'h80000000, 32'h0, 32'h0, 1'b1, '{32'h7FFFFFFF, 1'b1, 1'b1}},
    '{OP_J, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00400000, 1'b1, NoResult},
    '{OP_BEQ, 16'h8000, 32'h1, 32'h1, 32'h0, 1'b1, NoResult},
    '{OP_HALT, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, NoResult},
    '{OP_UNUSED, 16'h0004, 32'h100, 32'h0, 32'h0, 1'b1, NoResult}
  };

  execute_stage_alu u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .instr_low  (instr_low),
    .rs_value   (rs_value),
    .rt_value   (rt_value),
    .pc         (pc),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result),
    .overflow   (overflow),
    .has_result (has_result)
  );

  always #1 clk = ~clk;

  function automatic alu_out_t predict_alu(input logic [OpW-1:0] op, input logic [ImmW-1:0] low,
                                           input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                                           input logic [DataW-1:0] pc_val);
    logic [5:0]       fn;
    logic [4:0]       sh;
    logic [DataW-1:0] simm;
    logic [DataW-1:0] res;
    logic             ovf;
    logic             ok;
    alu_out_t         out;
    fn   = low[5:0];
    sh   = low[10:6];
    simm = {{16{low[15]}}, low};
    res  = '0;
    ovf  = 1'b0;
    ok   = 1'b1;
    case (op)
      OP_RTYPE: begin
        case (fn)
          FN_ADD: begin
            res = a + b;
            ovf = (~(a[31] ^ b[31])) & (a[31] ^ res[31]);
          end
          FN_ADDU: res = a + b;
          FN_SUB: begin
            res = a - b;
            ovf = (a[31] ^ b[31]) & (a[31] ^ res[31]);
          end
          FN_AND:  res = a & b;
          FN_OR:   res = a | b;
          FN_XOR:  res = a ^ b;
          FN_NOR:  res = ~(a | b);
          FN_NAND: res = ~(a & b);
          FN_SLT:  res = {31'd0, $signed(a) < $signed(b)};
          FN_SLL:  res = b << sh;
          FN_SRL:  res = b >> sh;
          FN_SRA:  res = $signed(b) >>> sh;
          default: ok = 1'b0;
        endcase
      end
      OP_ADDI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
        res = a + simm;
        ovf = (~(a[31] ^ simm[31])) & (a[31] ^ res[31]);
      end
      OP_ADDIU: res = a + simm;
      OP_SLTI:  res = {31'd0, $signed(a) < $signed(simm)};
      OP_ANDI:  res = a & {16'd0, low};
      OP_ORI:   res = a | {16'd0, low};
      OP_NORI:  res = ~(a | {16'd0, low});
      OP_LUI:   res = {low, 16'd0};
      OP_JAL:   res = pc_val + LinkOffset;
      default:  ok = 1'b0;
    endcase
    out.result     = ok ? res : '0;
    out.overflow   = ok ? ovf : 1'b0;
    out.has_result = ok;
    return out;
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return 32'hFFFFFFFF;
      4: return 32'($urandom_range(0, 16));
      5: return 32'h0 - 32'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ImmW-1:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed instructions, the rest odd functs and arbitrary opcodes
  task automatic make_random_instr(output logic [OpW-1:0] op, output logic [ImmW-1:0] low,
                                   output logic [DataW-1:0] a, output logic [DataW-1:0] b,
                                   output logic [DataW-1:0] pc_val);
    int unsigned pick;
    pick   = $urandom_range(0, 99);
    a      = pick_word();
    b      = pick_word();
    pc_val = pick_word();
    if (pick < 45) begin
      op  = OP_RTYPE;
      low = {5'($urandom), 5'($urandom), rtype_functs[$urandom_range(0, 11)]};
    end else if (pick < 80) begin
      op  = itype_ops[$urandom_range(0, 15)];
      low = pick_imm();
    end else if (pick < 90) begin
      op  = OP_RTYPE;
      low = 16'($urandom);
    end else begin
      op  = 6'($urandom);
      low = 16'($urandom);
    end
  endtask

  task automatic send_instr(input logic [OpW-1:0] op, input logic [ImmW-1:0] low,
                            input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                            input logic [DataW-1:0] pc_val, input alu_out_t want);
    @(negedge clk);
    in_valid    = 1'b1;
    opcode      = op;
    instr_low   = low;
    rs_value    = a;
    rt_value    = b;
    pc          = pc_val;
    next_expect = want;
    do @(posedge clk); while (in_stall);
  endtask

  // result check first, then record the input transfer of this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_alu = '{result, overflow, has_result};
        results_seen++;
        if (!has_result) no_result_seen++;
        if (overflow) overflow_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h ovf=%b has=%b with nothing pending",
                     result, overflow, has_result);
        end else begin
          want_alu = pending_results.pop_front();
          if (got_alu.result !== want_alu.result || got_alu.overflow !== want_alu.overflow ||
              got_alu.has_result !== want_alu.has_result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %h ovf=%b has=%b, got %h ovf=%b has=%b",
                       results_seen, want_alu.result, want_alu.overflow, want_alu.has_result,
                       got_alu.result, got_alu.overflow, got_alu.has_result);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(next_expect);
        items_accepted++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // receiver stall pattern, with one long hold-off that lets the block back up
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && items_accepted >= HoldAfter) begin
        held = 1'b1;
        repeat (HoldCycles) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 40);
        for (int i = 0; i < span; i++) begin
          @(negedge clk);
          case (mode)
            0: out_stall = 1'b0;
            1: out_stall = 1'($urandom_range(0, 1));
            2: out_stall = i[0];
            default: out_stall = ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(negedge clk);
    $display("no transfer for %0d cycles", IdleLimit);
    $display("execute_stage_alu verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [OpW-1:0]   op;
    logic [ImmW-1:0]  low;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] pc_val;
    alu_out_t         want;
    dir_row_t         row;
    int unsigned      burst_left;
    int unsigned      gap;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int idx = 0; idx < NumItems; idx++) begin
      if (idx == DrainAt) begin
        // hold back until the pipe has delivered everything
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        repeat (gap) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
      burst_left--;
      if (idx < NumDirected) begin
        row    = directed_rows[idx];
        op     = row.op;
        low    = row.low;
        a      = row.a;
        b      = row.b;
        pc_val = row.pc_val;
        want   = row.typed ? row.want : predict_alu(op, low, a, b, pc_val);
      end else begin
        make_random_instr(op, low, a, b, pc_val);
        want = predict_alu(op, low, a, b, pc_val);
      end
      send_instr(op, low, a, b, pc_val, want);
    end
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    $display("%0d instructions in, %0d results checked: %0d without result, %0d overflowed",
             items_accepted, results_seen, no_result_seen, overflow_seen);
    $display("bursty sender, patterned stalls, one long back-pressure hold and one drain pause;"
             , " %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("execute_stage_alu verification clean");
    end else begin
      $display("execute_stage_alu verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/esa_pkg.sv
rtl/core/esa_alu.sv
rtl/core/execute_stage_alu.sv
test/execute_stage_alu_tb.sv
